// ===== hw/rtl/kmeans_color_quantizer_defines.svh =====
// Assertion macros shared by the k-means color quantizer RTL.
`ifndef KMEANS_COLOR_QUANTIZER_DEFINES_SVH
`define KMEANS_COLOR_QUANTIZER_DEFINES_SVH
// Clocked implication check, silent during reset.
`define KCQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check, silent during reset.
`define KCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/kcq_pkg.sv =====
// Shared types and constants of the k-means color quantizer.
package kcq_pkg;
    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int MAX_PIXELS_DEF   = 1048576;
    // Counts have one bit above the nominal pixel budget; each channel sum adds seven bits.
    localparam int COUNT_W = $clog2(MAX_PIXELS_DEF) + 1;
    localparam int SUM_W   = COUNT_W + 7;
    localparam int DIST_W  = 18;
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [2:0]  centroid_index;
        logic [23:0] color_in;
        logic        last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  label_out;
        logic [23:0] color_out;
        logic        pass_done;
        logic        converged;
    } t_out_item;

    // Classified pixel handed from the front part to the back part.
    typedef struct packed {
        logic [5:0]  label;
        logic [23:0] color;
        logic [23:0] chosen;
        logic        last;
    } t_work;

    function automatic logic [7:0] chan(input logic [23:0] rgb, input int c);
        chan = rgb[16-8*c +: 8];
    endfunction
endpackage

// ===== hw/rtl/kmeans_color_quantizer.sv =====
// Top level of the k-means color quantizer: front classifier plus back accumulator.
// A pixel is compared with all N clusters in use; the back part then registers its result.
// Loads are taken every cycle while full is low; pixels wait until the front part is idle.
// A last pixel starts the bit-serial centroid division, three channels per cluster.
// Reset (synchronous, active low) clears sums, counts and control; cluster count is 8.
// The centroid table is not reset and must be loaded before pixels arrive.
module kmeans_color_quantizer #(
    parameter int MAX_CLUSTERS = kcq_pkg::MAX_CLUSTERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  kcq_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output kcq_pkg::t_out_item o_item
);
    import kcq_pkg::*;

    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    logic [3:0]    r_cluster_count;
    logic [IW-1:0] w_rd_idx;
    logic [23:0]   w_rd_data;
    logic          w_ld_we;
    logic [IW-1:0] w_ld_idx;
    logic [23:0]   w_ld_data;
    logic          w_wvalid;
    logic          w_wready;
    logic          w_busy;
    t_work         w_work;

    // The cluster count register; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cluster_count <= 4'd8;
        else if (i_cfg_we) r_cluster_count <= i_cfg_data;
    end

    // Front part: classifies one pixel at a time against the table.
    kcq_front #(.MAX_CLUSTERS(MAX_CLUSTERS), .IW(IW)) u_front (
        .i_clk, .i_rst_n, .i_cluster_count(r_cluster_count),
        .i_push(push), .o_full(full), .i_item,
        .o_rd_idx(w_rd_idx), .i_rd_data(w_rd_data),
        .o_ld_we(w_ld_we), .o_ld_idx(w_ld_idx), .o_ld_data(w_ld_data),
        .o_wvalid(w_wvalid), .o_work(w_work), .i_wready(w_wready), .i_busy(w_busy)
    );

    // Back part: owns the table, accumulators, divider and result register.
    kcq_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .IW(IW)) u_back (
        .i_clk, .i_rst_n, .i_cluster_count(r_cluster_count),
        .i_wvalid(w_wvalid), .i_work(w_work), .o_wready(w_wready), .o_busy(w_busy),
        .i_ld_we(w_ld_we), .i_ld_idx(w_ld_idx), .i_ld_data(w_ld_data),
        .i_rd_idx(w_rd_idx), .o_rd_data(w_rd_data),
        .o_empty(empty), .i_pop(pop), .o_item
    );
endmodule

// ===== hw/rtl/kcq_front.sv =====
// Front part: accepts items, loads centroids and labels pixels by a serial search.
module kcq_front #(
    parameter int MAX_CLUSTERS = kcq_pkg::MAX_CLUSTERS_DEF,
    parameter int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_cluster_count,
    input  logic              i_push,
    output logic              o_full,
    input  kcq_pkg::t_in_item i_item,
    // centroid table access shared with the back part's update
    output logic [IW-1:0]     o_rd_idx,
    input  logic [23:0]       i_rd_data,
    output logic              o_ld_we,
    output logic [IW-1:0]     o_ld_idx,
    output logic [23:0]       o_ld_data,
    output logic              o_wvalid,
    output kcq_pkg::t_work    o_work,
    input  logic              i_wready,
    input  logic              i_busy
);
    import kcq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SEND} t_state;

    t_state          r_state;
    t_in_item        r_item;
    logic [IW:0]     r_i;
    logic [IW-1:0]   r_best;
    logic [DIST_W-1:0] r_best_d;
    logic [23:0]     r_best_c;
    logic [IW:0]     w_n;
    logic [DIST_W-1:0] w_d;
    logic [8:0]      w_df [3];

    always_comb begin
        if (i_cluster_count == 4'd0) w_n = (IW+1)'(1);
        else if (32'(i_cluster_count) > MAX_CLUSTERS) w_n = (IW+1)'(MAX_CLUSTERS);
        else w_n = (IW+1)'(i_cluster_count);
    end

    always_comb begin
        w_d = '0;
        for (int c = 0; c < 3; c++) begin
            w_df[c] = {1'b0, chan(r_item.color_in, c)} - {1'b0, chan(i_rd_data, c)};
            if (w_df[c][8]) w_df[c] = -w_df[c];
            w_d = w_d + DIST_W'({8'd0, w_df[c][7:0]} * {8'd0, w_df[c][7:0]});
        end
    end

    assign o_rd_idx = r_i[IW-1:0];
    assign o_full = (r_state != S_IDLE) || i_busy;
    assign o_ld_we = i_push && !o_full && i_item.func == FUNC_LOAD
                     && 32'(i_item.centroid_index) < MAX_CLUSTERS;
    assign o_ld_idx = IW'(i_item.centroid_index);
    assign o_ld_data = i_item.color_in;
    assign o_wvalid = (r_state == S_SEND);
    always_comb begin
        o_work = '0;
        o_work.label = 6'(r_best);
        o_work.color = r_item.color_in;
        o_work.chosen = r_best_c;
        o_work.last = r_item.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push && !o_full && i_item.func == FUNC_PIXEL) begin
                        r_item <= i_item;
                        r_i <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_i == '0 || w_d < r_best_d) begin
                        r_best_d <= w_d;
                        r_best <= r_i[IW-1:0];
                        r_best_c <= i_rd_data;
                    end
                    if (r_i + 1'b1 >= w_n) r_state <= S_SEND;
                    r_i <= r_i + 1'b1;
                end
                S_SEND: begin
                    if (i_wready) begin
                        r_state <= S_IDLE;
                        r_i <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/kcq_back.sv =====
// Back part: accumulates pixels, recomputes centroids with a serial divider.
`include "kmeans_color_quantizer_defines.svh"
module kcq_back #(
    parameter int MAX_CLUSTERS = kcq_pkg::MAX_CLUSTERS_DEF,
    parameter int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_cluster_count,
    input  logic              i_wvalid,
    input  kcq_pkg::t_work    i_work,
    output logic              o_wready,
    output logic              o_busy,
    input  logic              i_ld_we,
    input  logic [IW-1:0]     i_ld_idx,
    input  logic [23:0]       i_ld_data,
    input  logic [IW-1:0]     i_rd_idx,
    output logic [23:0]       o_rd_data,
    output logic              o_empty,
    input  logic              i_pop,
    output kcq_pkg::t_out_item o_item
);
    import kcq_pkg::*;

    typedef enum logic [1:0] {S_RUN, S_DIV, S_DONE} t_state;

    logic [23:0]        r_cent [MAX_CLUSTERS];
    logic [SUM_W-1:0]   r_sum  [MAX_CLUSTERS][3];
    logic [COUNT_W-1:0] r_cnt  [MAX_CLUSTERS];
    t_state             r_state;
    t_out_item          r_out;
    logic               r_full;
    logic [IW:0]        r_ci;
    logic [1:0]         r_ch;
    logic [4:0]         r_bit;
    logic [SUM_W-1:0]   r_quo;
    logic [COUNT_W:0]   r_rem;
    logic [23:0]        r_nv;
    logic               r_chg;
    logic [IW:0]        w_n;
    logic [IW-1:0]      w_lab;
    logic [COUNT_W:0]   w_trial;
    logic [SUM_W-1:0]   w_dividend;
    logic [7:0]         w_q8;
    logic [SUM_W:0]     w_s [3];

    always_comb begin
        if (i_cluster_count == 4'd0) w_n = (IW+1)'(1);
        else if (32'(i_cluster_count) > MAX_CLUSTERS) w_n = (IW+1)'(MAX_CLUSTERS);
        else w_n = (IW+1)'(i_cluster_count);
    end

    assign w_lab = i_work.label[IW-1:0];
    assign o_rd_data = r_cent[i_rd_idx];
    assign o_wready = (r_state == S_RUN) && !r_full;
    // A waiting result only holds the work handoff; the table is busy only
    // while it is being recomputed.
    assign o_busy = (r_state != S_RUN);
    assign o_empty = !r_full;
    assign o_item = r_out;
    assign w_dividend = r_sum[r_ci[IW-1:0]][r_ch];
    assign w_trial = {r_rem[COUNT_W-1:0], w_dividend[r_bit]};
    assign w_q8 = (r_quo > SUM_W'(255)) ? 8'hFF : r_quo[7:0];
    always_comb
        for (int c = 0; c < 3; c++)
            w_s[c] = {1'b0, r_sum[w_lab][c]} + (SUM_W+1)'(chan(i_work.color, c));

    always_ff @(posedge i_clk) begin
        if (i_ld_we) r_cent[i_ld_idx] <= i_ld_data;
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_full <= 1'b0;
            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                r_cnt[k] <= '0;
                for (int c = 0; c < 3; c++) r_sum[k][c] <= '0;
            end
        end else begin
            if (i_pop && r_full) r_full <= 1'b0;
            case (r_state)
                S_RUN: begin
                    if (i_wvalid && o_wready) begin
                        for (int c = 0; c < 3; c++)
                            r_sum[w_lab][c] <= w_s[c][SUM_W] ? '1 : w_s[c][SUM_W-1:0];
                        if (r_cnt[w_lab] != '1) r_cnt[w_lab] <= r_cnt[w_lab] + 1'b1;
                        r_out.label_out <= 3'(w_lab);
                        r_out.color_out <= i_work.chosen;
                        r_out.pass_done <= i_work.last;
                        r_out.converged <= 1'b0;
                        if (i_work.last) begin
                            r_state <= S_DIV;
                            r_ci <= '0;
                            r_ch <= '0;
                            r_bit <= 5'(SUM_W-1);
                            r_rem <= '0;
                            r_chg <= 1'b0;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring
                    if (w_trial >= {1'b0, r_cnt[r_ci[IW-1:0]]}) begin
                        r_rem <= w_trial - {1'b0, r_cnt[r_ci[IW-1:0]]};
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    if (r_bit == '0) r_state <= S_DONE;
                    else r_bit <= r_bit - 1'b1;
                end
                S_DONE: begin
                    if (r_ch != 2'd3) begin
                        r_nv[16-8*r_ch +: 8] <= w_q8;
                        r_ch <= r_ch + 1'b1;
                        if (r_ch != 2'd2) begin
                            r_bit <= 5'(SUM_W-1);
                            r_rem <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        if (r_cnt[r_ci[IW-1:0]] != '0) begin
                            r_cent[r_ci[IW-1:0]] <= r_nv;
                            if (r_nv != r_cent[r_ci[IW-1:0]]) r_chg <= 1'b1;
                        end
                        if (r_ci + 1'b1 >= w_n) begin
                            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                                r_cnt[k] <= '0;
                                for (int c = 0; c < 3; c++) r_sum[k][c] <= '0;
                            end
                            r_out.converged <= !(r_chg || (r_cnt[r_ci[IW-1:0]] != '0
                                               && r_nv != r_cent[r_ci[IW-1:0]]));
                            r_full <= 1'b1;
                            r_state <= S_RUN;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                            r_ch <= '0;
                            r_bit <= 5'(SUM_W-1);
                            r_rem <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    `KCQ_ASSERT_IMPL(a_conv_needs_done, i_clk, i_rst_n, r_full && r_out.converged, r_out.pass_done, "converged without pass_done")
    `KCQ_ASSERT_IMPL(a_no_result_while_div, i_clk, i_rst_n, r_state == S_DIV, !r_full, "result shown during recompute")
    `KCQ_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_wvalid && o_wready && !i_work.last, r_full, "accepted pixel gave no result")
endmodule
